// ===== design/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define SSE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sparse set check failed");

// property checked on every rising edge, reset included
`define SSE_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("sparse set check failed");

`endif

// ===== design/sse_pkg.sv =====
package sse_pkg;

    localparam int FUNC_W = 2;
    localparam int KEY_W  = 10;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int SLOT_W = 8;
    localparam int OCC_W  = 9;

    typedef enum logic [FUNC_W-1:0] {
        FN_SET    = 2'd0,
        FN_GET    = 2'd1,
        FN_REMOVE = 2'd2,
        FN_CLEAR  = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE      = 2'd0,
        ST_ADDED     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_MAP,
        S_DENSE,
        S_EVAL,
        S_MOVE_RD,
        S_MOVE_WR
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic init_step;
        logic map_rd;
        logic hit_rd;
        logic last_rd;
        logic eval;
        logic move_wr;
        logic res_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic init_last;
        logic short_op;
        logic need_move;
    } t_sts;

endpackage

// ===== design/sse_ctrl.sv =====
module sse_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  sse_pkg::t_sts i_sts,
    output sse_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_done
);
    import sse_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= o_cmd.res_load;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (i_sts.init_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_MAP;
                end
            end
            S_MAP: begin
                n_state = i_sts.short_op ? S_IDLE : S_DENSE;
            end
            S_DENSE: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = i_sts.need_move ? S_MOVE_RD : S_IDLE;
            end
            S_MOVE_RD: begin
                n_state = S_MOVE_WR;
            end
            S_MOVE_WR: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.init_step = 1'b1;
            end
            S_IDLE: begin
                o_cmd.latch = i_start;
            end
            S_MAP: begin
                o_cmd.res_load = i_sts.short_op;
                o_cmd.map_rd   = !i_sts.short_op;
            end
            S_DENSE: begin
                o_cmd.hit_rd = 1'b1;
            end
            S_EVAL: begin
                o_cmd.eval     = 1'b1;
                o_cmd.res_load = !i_sts.need_move;
            end
            S_MOVE_RD: begin
                o_cmd.last_rd = 1'b1;
            end
            S_MOVE_WR: begin
                o_cmd.move_wr  = 1'b1;
                o_cmd.res_load = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

// ===== design/sse_dpath.sv =====
module sse_dpath #(
    parameter int KEY_SPACE   = 1024,
    parameter int CAPACITY    = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sse_pkg::t_cmd                i_cmd,
    output sse_pkg::t_sts                o_sts,
    input  logic [sse_pkg::FUNC_W-1:0]   i_func,
    input  logic [sse_pkg::KEY_W-1:0]    i_key,
    input  logic [sse_pkg::VAL_W-1:0]    i_value,
    output logic [sse_pkg::STAT_W-1:0]   o_status,
    output logic [sse_pkg::VAL_W-1:0]    o_data,
    output logic [sse_pkg::SLOT_W-1:0]   o_slot,
    output logic [sse_pkg::OCC_W-1:0]    o_occupancy
);
    import sse_pkg::*;

    localparam int KW  = $clog2(KEY_SPACE);
    localparam int SW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int KXW = (KW > KEY_W) ? KW : KEY_W;
    localparam int RW  = KXW + 1;
    localparam int VXW = (VALUE_WIDTH > VAL_W) ? VALUE_WIDTH : VAL_W;
    localparam int SXW = (SW > SLOT_W) ? SW : SLOT_W;
    localparam int OXW = (CW > OCC_W) ? CW : OCC_W;

    // sparse map, dense keys, dense values
    logic [SW-1:0]          r_smap_mem [KEY_SPACE];
    logic [KW-1:0]          r_kos_mem  [CAPACITY];
    logic [VALUE_WIDTH-1:0] r_vos_mem  [CAPACITY];

    t_func                  r_func;
    logic [KEY_W-1:0]       r_key;
    logic [VAL_W-1:0]       r_value;
    logic [KW-1:0]          r_init_addr;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic [SW-1:0]          r_smap_q;
    logic [KW-1:0]          r_kos_q;
    logic [VALUE_WIDTH-1:0] r_vos_q;
    logic [VALUE_WIDTH-1:0] r_hit_data;
    t_status                r_status;
    t_status                n_status;
    logic [VAL_W-1:0]       r_data;
    logic [VAL_W-1:0]       n_data;
    logic [SW-1:0]          r_slot;
    logic [SW-1:0]          n_slot;

    logic [KXW-1:0]         key_ext;
    logic [KW-1:0]          key_idx;
    logic                   key_in_range;
    logic [VXW-1:0]         val_ext;
    logic [VXW-1:0]         vos_ext;
    logic [VXW-1:0]         hit_ext;
    logic [SXW-1:0]         slot_ext;
    logic [OXW-1:0]         occ_ext;
    logic [CW-1:0]          cnt_dec;
    logic [SW-1:0]          last;
    logic [SW-1:0]          tail;
    logic                   found;
    logic                   full;

    logic                   smap_we;
    logic [KW-1:0]          smap_wa;
    logic [SW-1:0]          smap_wd;
    logic                   kos_we;
    logic [SW-1:0]          kos_wa;
    logic [KW-1:0]          kos_wd;
    logic                   vos_we;
    logic [SW-1:0]          vos_wa;
    logic [VALUE_WIDTH-1:0] vos_wd;
    logic [SW-1:0]          dense_ra;

    assign key_ext      = KXW'(r_key);
    assign key_idx      = key_ext[KW-1:0];
    assign key_in_range = (RW'(r_key) < RW'(KEY_SPACE));
    assign val_ext      = VXW'(r_value);
    assign vos_ext      = VXW'(r_vos_q);
    assign hit_ext      = VXW'(r_hit_data);
    assign cnt_dec      = r_count - CW'(1);
    assign last         = cnt_dec[SW-1:0];
    assign tail         = r_count[SW-1:0];
    // a key is live when its slot is in use and that slot points back at it
    assign found        = (CW'(r_smap_q) < r_count) && (r_kos_q == key_idx);
    assign full         = (r_count >= CW'(CAPACITY));

    assign o_sts.init_last = (r_init_addr == KW'(KEY_SPACE - 1));
    assign o_sts.short_op  = (r_func == FN_CLEAR) || !key_in_range;
    assign o_sts.need_move = (r_func == FN_REMOVE) && found && (r_smap_q != last);

    assign dense_ra = i_cmd.last_rd ? last : r_smap_q;

    always_comb begin
        n_status = ST_DONE;
        n_data   = '0;
        n_slot   = '0;
        n_count  = r_count;
        smap_we  = 1'b0;
        smap_wa  = key_idx;
        smap_wd  = tail;
        kos_we   = 1'b0;
        kos_wa   = tail;
        kos_wd   = key_idx;
        vos_we   = 1'b0;
        vos_wa   = tail;
        vos_wd   = val_ext[VALUE_WIDTH-1:0];

        if (i_cmd.init_step) begin
            smap_we = 1'b1;
            smap_wa = r_init_addr;
            smap_wd = '0;
        end

        // clear or key outside the key space
        if (i_cmd.res_load && !i_cmd.eval && !i_cmd.move_wr) begin
            if (r_func == FN_CLEAR) begin
                n_count = '0;
            end else begin
                n_status = ST_NOT_FOUND;
            end
        end

        if (i_cmd.eval) begin
            case (r_func)
                FN_SET: begin
                    if (found) begin
                        vos_we = 1'b1;
                        vos_wa = r_smap_q;
                        n_slot = r_smap_q;
                    end else if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        smap_we  = 1'b1;
                        kos_we   = 1'b1;
                        vos_we   = 1'b1;
                        n_count  = r_count + CW'(1);
                        n_status = ST_ADDED;
                        n_slot   = tail;
                    end
                end
                FN_GET: begin
                    if (found) begin
                        n_data = vos_ext[VAL_W-1:0];
                        n_slot = r_smap_q;
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end
                FN_REMOVE: begin
                    if (found) begin
                        n_data = vos_ext[VAL_W-1:0];
                        n_slot = r_smap_q;
                        if (!o_sts.need_move) begin
                            n_count = cnt_dec;
                        end
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end
                default: begin
                    n_status = ST_DONE;
                end
            endcase
        end

        // last entry fills the hole
        if (i_cmd.move_wr) begin
            vos_we  = 1'b1;
            vos_wa  = r_smap_q;
            vos_wd  = r_vos_q;
            kos_we  = 1'b1;
            kos_wa  = r_smap_q;
            kos_wd  = r_kos_q;
            smap_we = 1'b1;
            smap_wa = r_kos_q;
            smap_wd = r_smap_q;
            n_count = cnt_dec;
            n_data  = hit_ext[VAL_W-1:0];
            n_slot  = r_smap_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (smap_we) begin
            r_smap_mem[smap_wa] <= smap_wd;
        end
        if (i_cmd.map_rd) begin
            r_smap_q <= r_smap_mem[key_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (kos_we) begin
            r_kos_mem[kos_wa] <= kos_wd;
        end
        if (i_cmd.hit_rd || i_cmd.last_rd) begin
            r_kos_q <= r_kos_mem[dense_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (vos_we) begin
            r_vos_mem[vos_wa] <= vos_wd;
        end
        if (i_cmd.hit_rd || i_cmd.last_rd) begin
            r_vos_q <= r_vos_mem[dense_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_init_addr <= '0;
        end else begin
            if (i_cmd.init_step) begin
                r_init_addr <= r_init_addr + KW'(1);
            end
            if (i_cmd.res_load) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func  <= t_func'(i_func);
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (i_cmd.eval) begin
            r_hit_data <= r_vos_q;
        end
        if (i_cmd.res_load) begin
            r_status <= n_status;
            r_data   <= n_data;
            r_slot   <= n_slot;
        end
    end

    assign slot_ext    = SXW'(r_slot);
    assign occ_ext     = OXW'(r_count);
    assign o_status    = r_status;
    assign o_data      = r_data;
    assign o_slot      = slot_ext[SLOT_W-1:0];
    assign o_occupancy = occ_ext[OCC_W-1:0];

endmodule

// ===== design/sparse_set_engine.sv =====
// channel   direction  signals                                  transaction
// command   in         start, busy, i_func, i_key, i_value      start high while busy low
// result    out        o_done, o_status, o_data, o_slot,        o_done high for one cycle
//                      o_occupancy
//
// clear and keys outside the key space: finished in the sparse map state, with no dense read
// get and set: the sparse map read, followed by the dense read, then the evaluation
// remove: as get, or with a further read and write when the last dense entry moves into the hole
// after reset a clearing pass writes every sparse map entry while busy is high
// the result shows in the cycle busy drops; a new command may start in that cycle
// the receiver cannot stall, so there is no back pressure on the result side
module sparse_set_engine #(
    parameter int KEY_SPACE   = 1024,
    parameter int CAPACITY    = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [sse_pkg::FUNC_W-1:0]   i_func,
    input  logic [sse_pkg::KEY_W-1:0]    i_key,
    input  logic [sse_pkg::VAL_W-1:0]    i_value,
    output logic                         o_done,
    output logic [sse_pkg::STAT_W-1:0]   o_status,
    output logic [sse_pkg::VAL_W-1:0]    o_data,
    output logic [sse_pkg::SLOT_W-1:0]   o_slot,
    output logic [sse_pkg::OCC_W-1:0]    o_occupancy
);
    import sse_pkg::*;

    t_cmd cmd;
    t_sts sts;

    sse_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    sse_dpath #(
        .KEY_SPACE   (KEY_SPACE),
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_func      (i_func),
        .i_key       (i_key),
        .i_value     (i_value),
        .o_status    (o_status),
        .o_data      (o_data),
        .o_slot      (o_slot),
        .o_occupancy (o_occupancy)
    );

endmodule

// ===== design/sse_checker.sv =====
`include "assert_macros.svh"

module sse_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_done,
    input logic [sse_pkg::STAT_W-1:0]   o_status,
    input logic [sse_pkg::OCC_W-1:0]    o_occupancy
);
    import sse_pkg::*;

    // an accepted transaction makes the block busy in the next cycle, with no result yet
    `SSE_ASSERT(a_busy_after_start, i_clk, i_rst_n, start && !busy |=> busy && !o_done)

    // results only show once the block has gone idle
    `SSE_ASSERT(a_done_when_idle, i_clk, i_rst_n, o_done |-> !busy)

    // one result per transaction, never two in a row
    `SSE_ASSERT(a_done_single, i_clk, i_rst_n, o_done |=> !o_done)

    // an added key leaves the set non-empty
    `SSE_ASSERT(a_added_nonempty, i_clk, i_rst_n, o_done && (o_status == ST_ADDED) |-> (o_occupancy != '0))

endmodule

bind sparse_set_engine sse_checker u_sse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_done      (o_done),
    .o_status    (o_status),
    .o_occupancy (o_occupancy)
);

// ===== test/sse_scoreboard.sv =====
`timescale 1ns / 1ps

module sse_scoreboard #(
    parameter int KEY_SPACE = 1024,
    parameter int CAPACITY  = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic [sse_pkg::FUNC_W-1:0] i_func,
    input  logic [sse_pkg::KEY_W-1:0]  i_key,
    input  logic [sse_pkg::VAL_W-1:0]  i_value,
    input  logic                       o_done,
    input  logic [sse_pkg::STAT_W-1:0] o_status,
    input  logic [sse_pkg::VAL_W-1:0]  o_data,
    input  logic [sse_pkg::SLOT_W-1:0] o_slot,
    input  logic [sse_pkg::OCC_W-1:0]  o_occupancy,
    output int                         mismatch_count,
    output int                         replies_outstanding
);
    import sse_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  data;
        logic [SLOT_W-1:0] slot;
        logic [OCC_W-1:0]  occupancy;
    } t_reply;

    logic              key_present   [KEY_SPACE];
    int unsigned       slot_of_key   [KEY_SPACE];
    int unsigned       key_of_slot   [CAPACITY];
    logic [VAL_W-1:0]  value_of_slot [CAPACITY];
    int unsigned       live_entries;
    int                fault_tally;
    t_reply            replies_due [$];

    function automatic void forget_all();
        for (int k = 0; k < KEY_SPACE; k++) begin
            key_present[k] = 1'b0;
            slot_of_key[k] = 0;
        end
        live_entries = 0;
    endfunction

    // applies one transaction to the shadow set and returns the reply it must produce
    function automatic t_reply sparse_set_op(t_func op, int unsigned key,
                                             logic [VAL_W-1:0] value);
        t_reply      r;
        int unsigned slot;
        int unsigned last;
        int unsigned moved;
        r = '0;
        slot = 0;
        r.status = ST_DONE;
        if (op == FN_CLEAR) begin
            forget_all();
        end else if (key >= KEY_SPACE || (op != FN_SET && !key_present[key])) begin
            r.status = ST_NOT_FOUND;
        end else if (op == FN_SET) begin
            if (key_present[key]) begin
                slot = slot_of_key[key];
                value_of_slot[slot] = value;
            end else if (live_entries >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                slot = live_entries;
                key_of_slot[slot] = key;
                value_of_slot[slot] = value;
                slot_of_key[key] = slot;
                key_present[key] = 1'b1;
                live_entries++;
                r.status = ST_ADDED;
            end
        end else if (op == FN_GET) begin
            slot = slot_of_key[key];
            r.data = value_of_slot[slot];
        end else begin
            slot = slot_of_key[key];
            key_present[key] = 1'b0;
            r.data = value_of_slot[slot];
            last = live_entries - 1;
            // last dense entry fills the hole
            if (slot != last) begin
                moved = key_of_slot[last];
                value_of_slot[slot] = value_of_slot[last];
                key_of_slot[slot] = moved;
                slot_of_key[moved] = slot;
            end
            live_entries = last;
        end
        r.slot = slot[SLOT_W-1:0];
        r.occupancy = live_entries[OCC_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            forget_all();
            replies_due.delete();
        end else begin
            // the reply of the previous transaction may land on the edge that takes the next one
            if (o_done === 1'b1) begin
                if (replies_due.size() == 0) begin
                    $display("%0t: reply with no transaction pending, status %0d data %h",
                             $time, o_status, o_data);
                    fault_tally++;
                end else begin
                    want = replies_due.pop_front();
                    if (o_status !== want.status) begin
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, want.status, o_status);
                        fault_tally++;
                    end
                    if (o_data !== want.data) begin
                        $display("%0t: data expected %h, actual %h",
                                 $time, want.data, o_data);
                        fault_tally++;
                    end
                    if (o_slot !== want.slot) begin
                        $display("%0t: slot expected %0d, actual %0d",
                                 $time, want.slot, o_slot);
                        fault_tally++;
                    end
                    if (o_occupancy !== want.occupancy) begin
                        $display("%0t: occupancy expected %0d, actual %0d",
                                 $time, want.occupancy, o_occupancy);
                        fault_tally++;
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0) begin
                replies_due.push_back(sparse_set_op(t_func'(i_func), int'(i_key), i_value));
            end
        end
        mismatch_count <= fault_tally;
        replies_outstanding <= replies_due.size();
    end

endmodule

// ===== test/tb_sparse_set_engine.sv =====
`timescale 1ns / 1ps

module tb_sparse_set_engine;
    import sse_pkg::*;

    localparam int KEY_SPACE = 1024;
    localparam int CAPACITY  = 256;
    localparam int FILL_KEYS = CAPACITY + 8;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    logic [FUNC_W-1:0] i_func  = '0;
    logic [KEY_W-1:0]  i_key   = '0;
    logic [VAL_W-1:0]  i_value = '0;
    logic              busy;
    logic              o_done;
    logic [STAT_W-1:0] o_status;
    logic [VAL_W-1:0]  o_data;
    logic [SLOT_W-1:0] o_slot;
    logic [OCC_W-1:0]  o_occupancy;

    int                mismatch_count;
    int                replies_outstanding;
    int                idle_pct = 0;
    logic [KEY_W-1:0]  key_pool [16];

    always #5 i_clk = ~i_clk;

    sparse_set_engine #(
        .KEY_SPACE   (KEY_SPACE),
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VAL_W)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_func      (i_func),
        .i_key       (i_key),
        .i_value     (i_value),
        .o_done      (o_done),
        .o_status    (o_status),
        .o_data      (o_data),
        .o_slot      (o_slot),
        .o_occupancy (o_occupancy)
    );

    sse_scoreboard #(
        .KEY_SPACE (KEY_SPACE),
        .CAPACITY  (CAPACITY)
    ) i_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_func              (i_func),
        .i_key               (i_key),
        .i_value             (i_value),
        .o_done              (o_done),
        .o_status            (o_status),
        .o_data              (o_data),
        .o_slot              (o_slot),
        .o_occupancy         (o_occupancy),
        .mismatch_count      (mismatch_count),
        .replies_outstanding (replies_outstanding)
    );

    // returns on the edge that takes the transaction
    task automatic run_cmd(input t_func f, input logic [KEY_W-1:0] k,
                           input logic [VAL_W-1:0] v);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct && gap < 40) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_func  <= f;
        i_key   <= k;
        i_value <= v;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic random_ops(input int count);
        int    r;
        t_func f;
        logic [KEY_W-1:0] k;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 40)      f = FN_SET;
            else if (r < 65) f = FN_GET;
            else if (r < 97) f = FN_REMOVE;
            else             f = FN_CLEAR;
            // mostly a small pool so gets and removes hit live keys
            if ($urandom_range(99) < 85) k = key_pool[$urandom_range(15)];
            else                         k = KEY_W'($urandom);
            run_cmd(f, k, $urandom);
        end
    endtask

    initial begin
        #2_000_000;
        $display("[sparse_set_engine] ERROR");
        $finish;
    end

    initial begin
        int pcts [3];
        int base;
        int pick;
        pcts = '{0, 61, 29};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty set, extremes, overwrite, remove with and without a move
        run_cmd(FN_GET,    10'd0,    32'h0);
        run_cmd(FN_REMOVE, 10'd1023, 32'hFFFF_FFFF);
        run_cmd(FN_SET,    10'd0,    32'h0000_0000);
        run_cmd(FN_SET,    10'd1023, 32'hFFFF_FFFF);
        run_cmd(FN_SET,    10'd0,    32'hA5A5_5A5A);
        run_cmd(FN_GET,    10'd0,    32'h0);
        run_cmd(FN_GET,    10'd1023, 32'h0);
        run_cmd(FN_SET,    10'd512,  32'h5555_AAAA);
        run_cmd(FN_REMOVE, 10'd0,    32'h0);
        run_cmd(FN_GET,    10'd512,  32'h0);
        run_cmd(FN_REMOVE, 10'd1023, 32'h0);
        run_cmd(FN_REMOVE, 10'd1023, 32'h0);
        run_cmd(FN_GET,    10'd0,    32'h0);
        run_cmd(FN_SET,    10'd341,  32'h8000_0001);
        run_cmd(FN_CLEAR,  10'd682,  32'hDEAD_BEEF);
        run_cmd(FN_GET,    10'd512,  32'h0);
        run_cmd(FN_REMOVE, 10'd341,  32'h0);
        run_cmd(FN_SET,    10'd7,    32'h1234_5678);
        run_cmd(FN_SET,    10'd512,  32'h0F0F_F0F0);
        run_cmd(FN_REMOVE, 10'd512,  32'h0);
        run_cmd(FN_CLEAR,  10'd1023, 32'hFFFF_FFFF);

        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = pcts[ph];
            foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom);
            random_ops(100);
            if (ph == 1) begin
                // fill to capacity with distinct keys, then work around the full set
                base = $urandom_range(KEY_SPACE - 1);
                for (int i = 0; i < FILL_KEYS; i++) begin
                    run_cmd(FN_SET, KEY_W'((base + i * 7) % KEY_SPACE), $urandom);
                end
                for (int n = 0; n < 40; n++) begin
                    pick = $urandom_range(FILL_KEYS - 1);
                    case ($urandom_range(3))
                        0: run_cmd(FN_SET,
                                   KEY_W'((base + (FILL_KEYS + $urandom_range(700)) * 7)
                                          % KEY_SPACE), $urandom);
                        1: run_cmd(FN_GET, KEY_W'((base + pick * 7) % KEY_SPACE), $urandom);
                        2: run_cmd(FN_REMOVE, KEY_W'((base + pick * 7) % KEY_SPACE),
                                   $urandom);
                        default: run_cmd(FN_SET, KEY_W'((base + pick * 7) % KEY_SPACE),
                                         $urandom);
                    endcase
                end
            end
            run_cmd(FN_CLEAR, KEY_W'($urandom), $urandom);
        end
        start <= 1'b0;

        // let the last transaction reach the checker before polling it
        repeat (2) @(posedge i_clk);
        while (replies_outstanding != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && replies_outstanding == 0) begin
            $display("[sparse_set_engine] OK");
        end else begin
            $display("[sparse_set_engine] ERROR");
        end
        $finish;
    end

endmodule
